### hw/rtl/ecf_pkg.sv
// Shared types, codes and default sizes for the Euler circuit finder.
`timescale 1ns / 1ps
`default_nettype none
package ecf_pkg;

   // Default capacities
   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_DEGREE   = 16;
   localparam int DEF_MAX_EDGES    = 32;

   // Fixed field widths
   localparam int VERTEX_W = 7;
   localparam int STATUS_W = 2;

   // Reset value of the vertex count register
   localparam logic [VERTEX_W-1:0] VCOUNT_RESET = 7'd64;

   // Request actions
   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_RUN = 1'b1;

   // Result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_NOT_EULER = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CIRCUIT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic                action;
      logic [VERTEX_W-1:0] end_a;
      logic [VERTEX_W-1:0] end_b;
   } req_type;

   typedef struct packed {
      logic                item_kind;
      logic [STATUS_W-1:0] status;
      logic [VERTEX_W-1:0] vertex;
      logic                last;
   } rsp_type;

endpackage
`default_nettype wire

### hw/rtl/ecf_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ecf_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### hw/rtl/ecf_core.sv
// Edge store, reachability and degree checks, Hierholzer walk and result sequencing.
`timescale 1ns / 1ps
`default_nettype none
module ecf_core
   import ecf_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_DEGREE   = DEF_MAX_DEGREE,
   parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire req_type             req_data,
   input  wire logic [VERTEX_W-1:0] vcount,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data
);

   localparam int VAW    = $clog2(MAX_VERTICES);
   localparam int DW     = $clog2(MAX_DEGREE);
   localparam int NAW    = VAW + DW;
   localparam int NDEPTH = 1 << NAW;
   localparam int LW     = $clog2(MAX_DEGREE + 1);
   localparam int EW     = $clog2(MAX_EDGES + 1);
   localparam int SD     = MAX_EDGES + 2;
   localparam int SAW    = $clog2(SD);
   localparam int TW     = $clog2(SD + 1);
   localparam int CD     = MAX_EDGES + 1;
   localparam int CAW    = $clog2(CD);
   localparam int PW     = $clog2(CD + 1);
   localparam int QW     = $clog2(MAX_VERTICES + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_ADD_A, S_ADD_B, S_ADD_W2,
      S_R_POP, S_R_U, S_R_LEN, S_R_NB,
      S_C_ADDR, S_C_TEST,
      S_W_INIT, S_W_LEN, S_W_LU, S_W_POP, S_W_V, S_W_VL, S_W_SR, S_W_SH,
      S_E_STAT, S_E_VTX
   } state_type;

   function automatic logic [VAW-1:0] vidx(input logic [VERTEX_W-1:0] v);
      logic [VERTEX_W-1:0] t;
      t = v - VERTEX_W'(1);
      return t[VAW-1:0];
   endfunction

   function automatic logic [NAW-1:0] naddr(input logic [VERTEX_W-1:0] v,
                                            input logic [DW-1:0] d);
      return {vidx(v), d};
   endfunction

   state_type             state_ff;
   logic [VERTEX_W-1:0]   a_ff, b_ff, u_ff, tos_ff;
   logic [LW-1:0]         la_ff, lv_ff;
   logic [DW-1:0]         j_ff;
   logic [EW-1:0]         edge_ff;
   logic                  ovf_ff;
   logic [MAX_VERTICES-1:0] len_vld_ff, mark_ff;
   logic                  len_rv_ff;
   logic [QW-1:0]         qhead_ff, qtail_ff;
   logic [VAW-1:0]        cidx_ff;
   logic [TW-1:0]         top_ff;
   logic [PW-1:0]         plen_ff;
   logic [CAW-1:0]        eidx_ff;

   // memory ports
   logic                nbr_we;
   logic [NAW-1:0]      nbr_wa, nbr_ra;
   logic [VERTEX_W-1:0] nbr_wd, nbr_rd;
   logic                len_we;
   logic [VAW-1:0]      len_wa, len_ra;
   logic [LW-1:0]       len_wd, len_rd;
   logic                q_we;
   logic [VAW-1:0]      q_wa, q_ra;
   logic [VERTEX_W-1:0] q_wd, q_rd;
   logic                stk_we;
   logic [SAW-1:0]      stk_wa, stk_ra;
   logic [VERTEX_W-1:0] stk_wd, stk_rd;
   logic                cir_we;
   logic [CAW-1:0]      cir_wa, cir_ra;
   logic [VERTEX_W-1:0] cir_wd, cir_rd;

   // derived values
   logic [LW-1:0]       len_eff;
   logic                add_ok, run_go, add_fail, self_loop, chk_fail, found;
   logic [LW:0]         la_need, lb_need, j1x, j2x;
   logic [DW-1:0]       j1, j2;
   logic [TW-1:0]       top_m2;
   logic [PW-1:0]       plen_m1;

   ecf_ram #(.WIDTH(VERTEX_W), .DEPTH(NDEPTH)) u_nbr (
      .clock, .wr_en(nbr_we), .wr_addr(nbr_wa), .wr_data(nbr_wd),
      .rd_addr(nbr_ra), .rd_data(nbr_rd));
   ecf_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_len (
      .clock, .wr_en(len_we), .wr_addr(len_wa), .wr_data(len_wd),
      .rd_addr(len_ra), .rd_data(len_rd));
   ecf_ram #(.WIDTH(VERTEX_W), .DEPTH(MAX_VERTICES)) u_queue (
      .clock, .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));
   ecf_ram #(.WIDTH(VERTEX_W), .DEPTH(SD)) u_stack (
      .clock, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd));
   ecf_ram #(.WIDTH(VERTEX_W), .DEPTH(CD)) u_circ (
      .clock, .wr_en(cir_we), .wr_addr(cir_wa), .wr_data(cir_wd),
      .rd_addr(cir_ra), .rd_data(cir_rd));

   assign busy = (state_ff != S_IDLE);

   // shared decode
   always_comb begin
      len_eff   = len_rv_ff ? len_rd : '0;
      add_ok    = (req_data.end_a != '0) && (int'(req_data.end_a) <= MAX_VERTICES) &&
                  (req_data.end_b != '0) && (int'(req_data.end_b) <= MAX_VERTICES);
      run_go    = start && (req_data.action == ACT_RUN) && !ovf_ff;
      self_loop = (a_ff == b_ff);
      la_need   = (LW + 1)'(la_ff) + (self_loop ? (LW + 1)'(2) : (LW + 1)'(1));
      lb_need   = (LW + 1)'(len_eff) + (LW + 1)'(1);
      add_fail  = (edge_ff >= EW'(MAX_EDGES)) || (la_need > (LW + 1)'(MAX_DEGREE)) ||
                  (lb_need > (LW + 1)'(MAX_DEGREE));
      chk_fail  = ((len_eff != '0) && !mark_ff[cidx_ff]) || len_eff[0];
      found     = (nbr_rd == u_ff);
      j1        = j_ff + DW'(1);
      j2        = j_ff + DW'(2);
      j1x       = (LW + 1)'(j_ff) + (LW + 1)'(1);
      j2x       = (LW + 1)'(j_ff) + (LW + 1)'(2);
      top_m2    = top_ff - TW'(2);
      plen_m1   = plen_ff - PW'(1);
   end

   // memory port steering
   always_comb begin
      nbr_we = 1'b0; nbr_wa = '0; nbr_wd = '0; nbr_ra = '0;
      len_we = 1'b0; len_wa = '0; len_wd = '0; len_ra = '0;
      q_we   = 1'b0; q_wa   = '0; q_wd   = '0; q_ra   = '0;
      stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
      cir_we = 1'b0; cir_wa = '0; cir_wd = '0; cir_ra = '0;
      unique case (state_ff)
         S_IDLE: begin
            len_ra = vidx(req_data.end_a);
            q_we   = run_go;
            q_wd   = VERTEX_W'(1);
         end
         S_ADD_A: len_ra = vidx(b_ff);
         S_ADD_B: begin
            nbr_we = !add_fail;
            nbr_wa = naddr(a_ff, la_ff[DW-1:0]);
            nbr_wd = b_ff;
            len_we = !add_fail;
            len_wa = vidx(a_ff);
            len_wd = la_need[LW-1:0];
         end
         S_ADD_W2: begin
            nbr_we = 1'b1;
            nbr_wa = naddr(b_ff, lv_ff[DW-1:0]);
            nbr_wd = a_ff;
            len_we = 1'b1;
            len_wa = vidx(b_ff);
            len_wd = lv_ff + LW'(1);
         end
         S_R_POP: q_ra = qhead_ff[VAW-1:0];
         S_R_U:   len_ra = vidx(q_rd);
         S_R_LEN: nbr_ra = naddr(u_ff, '0);
         S_R_NB: begin
            nbr_ra = naddr(u_ff, j1);
            q_we   = !mark_ff[vidx(nbr_rd)];
            q_wa   = qtail_ff[VAW-1:0];
            q_wd   = nbr_rd;
         end
         S_C_ADDR: len_ra = cidx_ff;
         S_C_TEST: ;
         S_W_INIT: begin
            stk_we = 1'b1;
            stk_wd = VERTEX_W'(1);
         end
         S_W_LEN: len_ra = vidx(tos_ff);
         S_W_LU: begin
            if (len_eff != '0) begin
               nbr_ra = naddr(tos_ff, DW'(len_eff - LW'(1)));
               len_we = 1'b1;
               len_wa = vidx(tos_ff);
               len_wd = len_eff - LW'(1);
            end else begin
               cir_we = 1'b1;
               cir_wa = plen_ff[CAW-1:0];
               cir_wd = tos_ff;
               stk_ra = top_m2[SAW-1:0];
            end
         end
         S_W_POP: ;
         S_W_V: begin
            stk_we = 1'b1;
            stk_wa = top_ff[SAW-1:0];
            stk_wd = nbr_rd;
            len_ra = vidx(nbr_rd);
         end
         S_W_VL: nbr_ra = naddr(tos_ff, '0);
         S_W_SR: begin
            nbr_ra = naddr(tos_ff, j1);
            len_we = found;
            len_wa = vidx(tos_ff);
            len_wd = lv_ff - LW'(1);
         end
         S_W_SH: begin
            nbr_we = 1'b1;
            nbr_wa = naddr(tos_ff, j_ff);
            nbr_wd = nbr_rd;
            nbr_ra = naddr(tos_ff, j2);
         end
         S_E_STAT: cir_ra = plen_m1[CAW-1:0];
         S_E_VTX:  cir_ra = eidx_ff - CAW'(1);
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         edge_ff    <= '0;
         ovf_ff     <= 1'b0;
         len_vld_ff <= '0;
         mark_ff    <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         len_rv_ff  <= len_vld_ff[len_ra];
         if (len_we) begin
            len_vld_ff[len_wa] <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  a_ff <= req_data.end_a;
                  b_ff <= req_data.end_b;
                  if (req_data.action == ACT_RUN) begin
                     if (ovf_ff) begin
                        rsp_strobe <= 1'b1;
                        rsp_data   <= '{KIND_STATUS, ST_OVERFLOW, '0, 1'b1};
                        edge_ff    <= '0;
                        ovf_ff     <= 1'b0;
                        len_vld_ff <= '0;
                        mark_ff    <= '0;
                     end else begin
                        mark_ff[0] <= 1'b1;
                        qhead_ff   <= '0;
                        qtail_ff   <= QW'(1);
                        state_ff   <= S_R_POP;
                     end
                  end else if (add_ok) begin
                     state_ff <= S_ADD_A;
                  end
               end
            end
            S_ADD_A: begin
               la_ff    <= len_eff;
               state_ff <= S_ADD_B;
            end
            S_ADD_B: begin
               if (add_fail) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  lv_ff    <= self_loop ? la_ff + LW'(1) : len_eff;
                  state_ff <= S_ADD_W2;
               end
            end
            S_ADD_W2: begin
               edge_ff  <= edge_ff + EW'(1);
               state_ff <= S_IDLE;
            end
            // breadth-first reachability from vertex 1
            S_R_POP: begin
               if (qhead_ff == qtail_ff) begin
                  cidx_ff  <= '0;
                  state_ff <= S_C_ADDR;
               end else begin
                  qhead_ff <= qhead_ff + QW'(1);
                  state_ff <= S_R_U;
               end
            end
            S_R_U: begin
               u_ff     <= q_rd;
               state_ff <= S_R_LEN;
            end
            S_R_LEN: begin
               lv_ff    <= len_eff;
               j_ff     <= '0;
               state_ff <= (len_eff == '0) ? S_R_POP : S_R_NB;
            end
            S_R_NB: begin
               if (!mark_ff[vidx(nbr_rd)]) begin
                  mark_ff[vidx(nbr_rd)] <= 1'b1;
                  qtail_ff <= qtail_ff + QW'(1);
               end
               j_ff <= j1;
               if (j1x == (LW + 1)'(lv_ff)) begin
                  state_ff <= S_R_POP;
               end
            end
            // degree and reachability checks over the counted vertices
            S_C_ADDR: state_ff <= S_C_TEST;
            S_C_TEST: begin
               if (chk_fail) begin
                  rsp_strobe <= 1'b1;
                  rsp_data   <= '{KIND_STATUS, ST_NOT_EULER, '0, 1'b1};
                  edge_ff    <= '0;
                  ovf_ff     <= 1'b0;
                  len_vld_ff <= '0;
                  mark_ff    <= '0;
                  state_ff   <= S_IDLE;
               end else if (VERTEX_W'(cidx_ff) == vcount - VERTEX_W'(1)) begin
                  // vertices past the count walk as empty
                  for (int k = 0; k < MAX_VERTICES; k++) begin
                     if (k >= int'(vcount)) begin
                        len_vld_ff[k] <= 1'b0;
                     end
                  end
                  state_ff <= S_W_INIT;
               end else begin
                  cidx_ff  <= cidx_ff + VAW'(1);
                  state_ff <= S_C_ADDR;
               end
            end
            // Hierholzer walk
            S_W_INIT: begin
               top_ff   <= TW'(1);
               tos_ff   <= VERTEX_W'(1);
               plen_ff  <= '0;
               state_ff <= S_W_LEN;
            end
            S_W_LEN: state_ff <= S_W_LU;
            S_W_LU: begin
               if (len_eff != '0) begin
                  u_ff     <= tos_ff;
                  state_ff <= S_W_V;
               end else begin
                  plen_ff  <= plen_ff + PW'(1);
                  top_ff   <= top_ff - TW'(1);
                  state_ff <= (top_ff == TW'(1)) ? S_E_STAT : S_W_POP;
               end
            end
            S_W_POP: begin
               tos_ff   <= stk_rd;
               state_ff <= S_W_LEN;
            end
            S_W_V: begin
               top_ff   <= top_ff + TW'(1);
               tos_ff   <= nbr_rd;
               state_ff <= S_W_VL;
            end
            S_W_VL: begin
               lv_ff    <= len_eff;
               j_ff     <= '0;
               state_ff <= (len_eff == '0) ? S_W_LEN : S_W_SR;
            end
            // find first back entry, then close the gap
            S_W_SR: begin
               if (found) begin
                  state_ff <= (j1x < (LW + 1)'(lv_ff)) ? S_W_SH : S_W_LEN;
               end else begin
                  j_ff <= j1;
                  if (j1x == (LW + 1)'(lv_ff)) begin
                     state_ff <= S_W_LEN;
                  end
               end
            end
            S_W_SH: begin
               j_ff <= j1;
               if (j2x >= (LW + 1)'(lv_ff)) begin
                  state_ff <= S_W_LEN;
               end
            end
            // results
            S_E_STAT: begin
               rsp_strobe <= 1'b1;
               rsp_data   <= '{KIND_STATUS, ST_CIRCUIT, '0, 1'b0};
               eidx_ff    <= plen_m1[CAW-1:0];
               state_ff   <= S_E_VTX;
            end
            S_E_VTX: begin
               rsp_strobe <= 1'b1;
               rsp_data   <= '{KIND_VERTEX, ST_NOT_EULER, cir_rd, (eidx_ff == '0)};
               eidx_ff    <= eidx_ff - CAW'(1);
               if (eidx_ff == '0) begin
                  edge_ff    <= '0;
                  ovf_ff     <= 1'b0;
                  len_vld_ff <= '0;
                  mark_ff    <= '0;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

### hw/rtl/euler_circuit_finder.sv
// Top level: vertex count register and the circuit finder core.
`timescale 1ns / 1ps
`default_nettype none
// Euler circuit finder. An edge request keeps busy high while it is stored, so
// edges are taken one at a time; a request with a bad endpoint is dropped at
// once. A run request takes a breadth-first reachability pass: a queue pop, a
// vertex read and a length read per reached vertex, a neighbor read per stored
// list entry, and a last pop to finish. Then come the degree and reachability
// checks over the counted vertices. The walk follows each edge and scans or
// shifts neighbor entries to erase the back entry. After that the status goes
// out, followed by one circuit vertex per cycle. The neighbor-list memory has a
// single read port. busy stays high until the last result has been launched;
// results come on rsp_strobe for one cycle each and cannot be held off. The
// store needs no clearing pass after reset.
module euler_circuit_finder
   import ecf_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_DEGREE   = DEF_MAX_DEGREE,
   parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire req_type             req_data,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [VERTEX_W-1:0] csr_data
);

   logic [VERTEX_W-1:0] vcount_ff;
   logic [VERTEX_W-1:0] vcount_eff;

   assign csr_ready = 1'b1;

   // vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         vcount_ff <= csr_data;
      end
   end

   // clamp count into 1..MAX_VERTICES
   always_comb begin
      if (vcount_ff == '0) begin
         vcount_eff = VERTEX_W'(1);
      end else if (int'(vcount_ff) > MAX_VERTICES) begin
         vcount_eff = VERTEX_W'(MAX_VERTICES);
      end else begin
         vcount_eff = vcount_ff;
      end
   end

   ecf_core #(
      .MAX_VERTICES(MAX_VERTICES),
      .MAX_DEGREE  (MAX_DEGREE),
      .MAX_EDGES   (MAX_EDGES)
   ) u_core (
      .clock,
      .reset,
      .start,
      .busy,
      .req_data,
      .vcount(vcount_eff),
      .rsp_strobe,
      .rsp_data
   );

endmodule
`default_nettype wire

### test/euler_circuit_checker.sv
// Checker for the Euler circuit finder: predicts every run and compares results.
`timescale 1ns / 1ps
`default_nettype none
module euler_circuit_checker
   import ecf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire req_type             req_data,
   input  wire logic                rsp_strobe,
   input  wire rsp_type             rsp_data,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic [VERTEX_W-1:0] csr_data,
   output int                       fail_count,
   output int                       pending_count,
   output int                       circuits_seen
);

   localparam int NV = DEF_MAX_VERTICES;
   localparam int ND = DEF_MAX_DEGREE;
   localparam int NE = DEF_MAX_EDGES;

   // Shadow graph store and register
   logic [VERTEX_W-1:0] adj [1:NV][0:ND-1];
   int                  deg [0:NV];
   bit                  reached [0:NV];
   int                  edge_cnt;
   bit                  overflowed;
   logic [VERTEX_W-1:0] vcount;

   rsp_type circuit_q[$];

   function automatic rsp_type mk_rsp(logic kind, logic [STATUS_W-1:0] st,
                                      logic [VERTEX_W-1:0] vx, logic lst);
      rsp_type r;
      r.item_kind = kind;
      r.status    = st;
      r.vertex    = vx;
      r.last      = lst;
      return r;
   endfunction

   // Append one expected result
   task automatic expect_rsp(rsp_type r);
      circuit_q.insert(circuit_q.size(), r);
   endtask

   task automatic clear_graph();
      for (int i = 0; i <= NV; i++) begin
         deg[i]     = 0;
         reached[i] = 0;
      end
      edge_cnt   = 0;
      overflowed = 0;
   endtask

   task automatic add_edge(int a, int b);
      int need;
      need = (a == b) ? 2 : 1;
      if (a < 1 || a > NV || b < 1 || b > NV) return;
      if (edge_cnt >= NE || deg[a] + need > ND || deg[b] + 1 > ND) begin
         overflowed = 1;
         return;
      end
      adj[a][deg[a]] = b[VERTEX_W-1:0];
      deg[a]++;
      adj[b][deg[b]] = a[VERTEX_W-1:0];
      deg[b]++;
      edge_cnt++;
   endtask

   // Reachability, parity check and Hierholzer walk from vertex 1
   task automatic predict_run();
      int n, top, plen, u, v, work[$];
      int walk [0:NE+1];
      int path [0:NE];
      n = vcount;
      if (n < 1) n = 1;
      if (n > NV) n = NV;
      if (overflowed) begin
         expect_rsp(mk_rsp(KIND_STATUS, ST_OVERFLOW, '0, 1'b1));
         return;
      end
      reached[1] = 1;
      work.insert(work.size(), 1);
      while (work.size() > 0) begin
         u = work.pop_front();
         for (int i = 0; i < deg[u]; i++) begin
            v = adj[u][i];
            if (!reached[v]) begin
               reached[v] = 1;
               work.insert(work.size(), v);
            end
         end
      end
      for (int i = 1; i <= n; i++) begin
         if ((deg[i] != 0 && !reached[i]) || deg[i][0]) begin
            expect_rsp(mk_rsp(KIND_STATUS, ST_NOT_EULER, '0, 1'b1));
            return;
         end
      end
      for (int i = n + 1; i <= NV; i++) deg[i] = 0;
      top = 0;
      plen = 0;
      walk[top++] = 1;
      while (top > 0) begin
         u = walk[top-1];
         if (deg[u] > 0) begin
            v = adj[u][deg[u]-1];
            deg[u]--;
            // drop the first back-reference to u in v's list
            for (int i = 0; i < deg[v]; i++) begin
               if (adj[v][i] == u) begin
                  for (int j = i; j + 1 < deg[v]; j++) adj[v][j] = adj[v][j+1];
                  deg[v]--;
                  break;
               end
            end
            if (top < NE + 2) walk[top++] = v;
         end else begin
            if (plen < NE + 1) path[plen++] = u;
            top--;
         end
      end
      expect_rsp(mk_rsp(KIND_STATUS, ST_CIRCUIT, '0, 1'b0));
      for (int i = 0; i < plen; i++)
         expect_rsp(mk_rsp(KIND_VERTEX, ST_NOT_EULER,
                           path[plen-1-i][VERTEX_W-1:0], i + 1 == plen));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_graph();
         circuit_q.delete();
         vcount        <= VCOUNT_RESET;
         fail_count    <= 0;
         circuits_seen <= 0;
         pending_count <= 0;
      end else begin
         // compare results against the oldest expectation
         if (rsp_strobe) begin
            if (circuit_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result kind=%0d st=%0d vx=%0d last=%0d", $time,
                           rsp_data.item_kind, rsp_data.status, rsp_data.vertex, rsp_data.last);
               fail_count <= fail_count + 1;
            end else begin
               want = circuit_q.pop_front();
               if (want.item_kind != rsp_data.item_kind || want.status != rsp_data.status ||
                   want.vertex != rsp_data.vertex || want.last != rsp_data.last) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              $time, want.item_kind, want.status, want.vertex, want.last,
                              rsp_data.item_kind, rsp_data.status, rsp_data.vertex,
                              rsp_data.last);
                  fail_count <= fail_count + 1;
               end
               if (want.item_kind == KIND_STATUS && want.status == ST_CIRCUIT)
                  circuits_seen <= circuits_seen + 1;
            end
         end
         // accepted request
         if (start && !busy) begin
            if (req_data.action == ACT_ADD) begin
               add_edge(req_data.end_a, req_data.end_b);
            end else begin
               predict_run();
               clear_graph();
            end
         end
         if (csr_valid && csr_ready) vcount <= csr_data;
         pending_count <= circuit_q.size();
      end
   end

endmodule
`default_nettype wire

### test/euler_circuit_finder_tb.sv
// Testbench top: stimulus for the Euler circuit finder and the final verdict.
`timescale 1ns / 1ps
`default_nettype none
module euler_circuit_finder_tb;
   import ecf_pkg::*;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [VERTEX_W-1:0] csr_data;
   int                  fail_count;
   int                  pending_count;
   int                  circuits_seen;

   int sent_items;
   int run_items;
   int cfg_writes;
   bit quiet_tail;

   euler_circuit_finder i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   euler_circuit_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .circuits_seen(circuits_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous watchdog
   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   // One request; an occasional burst of idle cycles first
   task automatic send(logic act, int a, int b);
      int gap;
      gap = 0;
      if (!quiet_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_data.action <= act;
      req_data.end_a  <= a[VERTEX_W-1:0];
      req_data.end_b  <= b[VERTEX_W-1:0];
      do @(posedge clock); while (busy);
      sent_items++;
      if (act == ACT_RUN) run_items++;
   endtask

   task automatic run_graph();
      send(ACT_RUN, $urandom_range(0, 127), $urandom_range(0, 127));
   endtask

   // Wait for every expected result, then let the core settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (busy || pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_vcount(int value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value[VERTEX_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_writes++;
   endtask

   // Random closed walks, first through vertex 1; edges shuffled, flipped
   task automatic euler_graph();
      int hi, loops, len, cur, first, nxt, n, t;
      int ea[$], eb[$], seen[$];
      hi = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 8);
      loops = $urandom_range(1, 3);
      seen.insert(seen.size(), 1);
      for (int l = 0; l < loops; l++) begin
         first = seen[$urandom_range(0, seen.size() - 1)];
         cur = first;
         len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            nxt = (k == len - 1) ? first : $urandom_range(1, hi);
            ea.insert(ea.size(), cur);
            eb.insert(eb.size(), nxt);
            seen.insert(seen.size(), nxt);
            cur = nxt;
         end
      end
      n = ea.size();
      for (int i = n - 1; i > 0; i--) begin
         int j;
         j = $urandom_range(0, i);
         t = ea[i]; ea[i] = ea[j]; ea[j] = t;
         t = eb[i]; eb[i] = eb[j]; eb[j] = t;
      end
      for (int i = 0; i < n; i++)
         if ($urandom_range(0, 1)) send(ACT_ADD, ea[i], eb[i]);
         else send(ACT_ADD, eb[i], ea[i]);
      run_graph();
   endtask

   // Random edges, some with bad endpoints
   task automatic noise_graph();
      int cnt;
      cnt = $urandom_range(1, 10);
      for (int i = 0; i < cnt; i++) begin
         if ($urandom_range(0, 5) == 0)
            send(ACT_ADD, $urandom_range(0, 127), $urandom_range(0, 127));
         else
            send(ACT_ADD, $urandom_range(1, 10), $urandom_range(1, 10));
      end
      run_graph();
   endtask

   // Too many edges or too high a degree
   task automatic overflow_graph();
      if ($urandom_range(0, 1)) begin
         for (int i = 0; i < 33; i++) send(ACT_ADD, $urandom_range(1, 20), $urandom_range(1, 20));
      end else begin
         for (int i = 0; i < 9; i++) send(ACT_ADD, 1, 1);
      end
      run_graph();
   endtask

   initial begin
      int pick;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      sent_items = 0;
      run_items  = 0;
      cfg_writes = 0;
      quiet_tail = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty graph, self loop, triangle, odd degree, unreachable
      run_graph();
      send(ACT_ADD, 0, 5);
      send(ACT_ADD, 127, 1);
      send(ACT_ADD, 1, 1);
      run_graph();
      send(ACT_ADD, 1, 2);
      send(ACT_ADD, 2, 3);
      send(ACT_ADD, 3, 1);
      run_graph();
      send(ACT_ADD, 1, 2);
      run_graph();
      send(ACT_ADD, 2, 3);
      send(ACT_ADD, 3, 2);
      run_graph();
      send(ACT_ADD, 64, 1);
      send(ACT_ADD, 1, 64);
      run_graph();
      // Vertex beyond the count: odd vertex 3 not checked
      write_vcount(2);
      send(ACT_ADD, 1, 2);
      send(ACT_ADD, 2, 1);
      send(ACT_ADD, 2, 3);
      run_graph();
      write_vcount(0);
      send(ACT_ADD, 1, 64);
      send(ACT_ADD, 64, 1);
      run_graph();
      write_vcount(127);
      send(ACT_ADD, 64, 64);
      run_graph();

      // Random phases, register changed now and then between them
      while (sent_items < 230) begin
         if (sent_items > 200) quiet_tail = 1'b1;
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 4))
               0: write_vcount(1);
               1: write_vcount(64);
               2: write_vcount(0);
               3: write_vcount(127);
               default: write_vcount($urandom_range(1, 64));
            endcase
         end
         pick = $urandom_range(0, 9);
         if (pick < 6) euler_graph();
         else if (pick < 9) noise_graph();
         else overflow_graph();
      end
      start <= 1'b0;

      fork
         begin
            drain();
            repeat (100) @(posedge clock);
         end
         begin
            repeat (200000) @(posedge clock);
            $display("Verification failed");
            $finish;
         end
      join_any

      $display("Sent %0d requests (%0d runs, %0d circuits found), %0d count writes.",
               sent_items, run_items, circuits_seen, cfg_writes);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
hw/rtl/ecf_pkg.sv
hw/rtl/ecf_ram.sv
hw/rtl/ecf_core.sv
hw/rtl/euler_circuit_finder.sv
test/euler_circuit_checker.sv
test/euler_circuit_finder_tb.sv
